// ===== design/sliding_log_rate_limiter_assert.svh =====
// Assertion macros for the sliding-window log rate limiter.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef SLIDING_LOG_RATE_LIMITER_ASSERT_SVH
`define SLIDING_LOG_RATE_LIMITER_ASSERT_SVH

// Overlapping implication, checked outside reset.
`define SLR_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rate limiter assertion failed");

// Implication into the next cycle, checked outside reset.
`define SLR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rate limiter assertion failed");

`endif

// ===== design/slr_pkg.sv =====
// Package for the sliding-window log rate limiter.
// Holds the fixed field widths, the retry ceiling and the sequencer state type.
package slr_pkg;

  localparam int TIME_W    = 40;
  localparam int KEY_W     = 8;
  localparam int LIMIT_W   = 5;
  localparam int WIN_SEC_W = 12;
  localparam int RETRY_W   = 12;
  localparam int RETRY_MAX = 4095;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_LOAD,
    ST_DECIDE,
    ST_RETRY
  } state_t;

endpackage

// ===== design/sliding_log_rate_limiter.sv =====
// Sliding-window log rate limiter, top level.
// Depends on slr_pkg and on the assertion macros in sliding_log_rate_limiter_assert.svh.
//
// A request beat is taken at a rising edge with start high and busy low. It carries
// key_slot, now_time (seconds with FRAC_BITS fraction bits), hit_limit and
// window_seconds. Each request gives one result beat: allowed and retry_after are
// valid for the single cycle in which done is high, and the receiver takes it then.
//
// Each slot keeps a circular log of up to MAX_HITS stamps in a stamp memory and its
// oldest position and count in a slot memory; both have a registered read port.
// The sequencer reads the slot entry, then drops one expired stamp per cycle from the
// front of the log, then allows and records the stamp or computes the retry delay.
// The number p of stamps dropped is at most MAX_HITS for an allowed request and
// MAX_HITS - 1 for a denied one. done is registered from ST_DECIDE when allowed and
// from ST_RETRY when denied; a request's length is set by the one-stamp-per-cycle
// pop loop on the stamp memory's read port.
// busy is high from the accepting edge until the result is written.
//
// After reset the slot memory is cleared, one slot per cycle, over all KEY_SLOTS slots
// with busy held high. The stamp memory is not cleared; only written stamps are read.
module sliding_log_rate_limiter #(
  parameter int KEY_SLOTS = 256,
  parameter int MAX_HITS  = 16,
  parameter int FRAC_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [slr_pkg::KEY_W-1:0]   key_slot,
  input  logic [slr_pkg::TIME_W-1:0]  now_time,
  input  logic [slr_pkg::LIMIT_W-1:0] hit_limit,
  input  logic [slr_pkg::WIN_SEC_W-1:0] window_seconds,
  output logic                        done,
  output logic                        allowed,
  output logic [slr_pkg::RETRY_W-1:0] retry_after
);

  localparam int SLOT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int PTR_W   = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CNT_W   = $clog2(MAX_HITS + 1);
  localparam int META_W  = PTR_W + CNT_W;
  localparam int LIM_W   = (CNT_W > slr_pkg::LIMIT_W) ? CNT_W : slr_pkg::LIMIT_W;
  localparam int WIN_W   = slr_pkg::WIN_SEC_W + FRAC_BITS;
  localparam int SUM_W   = slr_pkg::TIME_W + 1;
  localparam int ADDR_W  = SLOT_W + PTR_W;
  localparam int KEY_NUM = 1 << slr_pkg::KEY_W;

  slr_pkg::state_t state, state_next;

  logic [SLOT_W-1:0]         slot_tab [KEY_NUM];
  logic [SLOT_W-1:0]         slot_in;
  logic [LIM_W-1:0]          lim_in;
  logic [SLOT_W-1:0]         clr_addr;
  logic [SLOT_W-1:0]         slot_q;
  logic [slr_pkg::TIME_W-1:0] now_q;
  logic [LIM_W-1:0]          lim_q;
  logic [WIN_W-1:0]          win_q;
  logic [PTR_W-1:0]          head_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [SUM_W-1:0]          sum_q;
  logic [SUM_W-1:0]          diff_q;

  logic [META_W-1:0]         meta_mem [KEY_SLOTS];
  logic [META_W-1:0]         meta_rdata;
  logic                      meta_we;
  logic [SLOT_W-1:0]         meta_waddr;
  logic [META_W-1:0]         meta_wdata;

  logic [slr_pkg::TIME_W-1:0] stamp_mem [1 << ADDR_W];
  logic [slr_pkg::TIME_W-1:0] stamp_rdata;
  logic                      stamp_we;
  logic [PTR_W-1:0]          rd_ptr;
  logic [PTR_W-1:0]          head_inc;
  logic [PTR_W:0]            tail_sum;
  logic [PTR_W-1:0]          tail;
  logic [SUM_W-1:0]          stamp_sum;
  logic                      expired;
  logic                      deny;
  logic [SUM_W-1:0]          secs_raw;
  logic [slr_pkg::RETRY_W-1:0] retry_calc;

  logic                      done_next;
  logic                      allowed_next;
  logic [slr_pkg::RETRY_W-1:0] retry_next;

  for (genvar g = 0; g < KEY_NUM; g++) begin : g_slot_tab
    assign slot_tab[g] = SLOT_W'(g % KEY_SLOTS);
  end

  assign slot_in = slot_tab[key_slot];

  always_comb begin
    if (hit_limit == '0) begin
      lim_in = LIM_W'(1);
    end else if (LIM_W'(hit_limit) > LIM_W'(MAX_HITS)) begin
      lim_in = LIM_W'(MAX_HITS);
    end else begin
      lim_in = LIM_W'(hit_limit);
    end
  end

  assign head_inc  = (head_q == PTR_W'(MAX_HITS - 1)) ? '0 : head_q + PTR_W'(1);
  assign tail_sum  = {1'b0, head_q} + (PTR_W + 1)'(cnt_q);
  assign tail      = (tail_sum >= (PTR_W + 1)'(MAX_HITS)) ?
                     PTR_W'(tail_sum - (PTR_W + 1)'(MAX_HITS)) : PTR_W'(tail_sum);
  assign stamp_sum = SUM_W'(stamp_rdata) + SUM_W'(win_q);
  assign expired   = (cnt_q != '0) && (stamp_sum <= SUM_W'(now_q));
  assign deny      = LIM_W'(cnt_q) >= lim_q;
  assign secs_raw  = diff_q >> FRAC_BITS;
  assign retry_calc = (secs_raw >= SUM_W'(slr_pkg::RETRY_MAX)) ?
                      slr_pkg::RETRY_W'(slr_pkg::RETRY_MAX) :
                      slr_pkg::RETRY_W'(secs_raw) + slr_pkg::RETRY_W'(1);

  always_comb begin
    if (state == slr_pkg::ST_META) begin
      rd_ptr = meta_rdata[META_W-1:CNT_W];
    end else if (expired) begin
      rd_ptr = head_inc;
    end else begin
      rd_ptr = head_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    meta_we      = 1'b0;
    meta_waddr   = slot_q;
    meta_wdata   = {head_q, cnt_q};
    stamp_we     = 1'b0;
    done_next    = 1'b0;
    allowed_next = 1'b0;
    retry_next   = '0;
    unique case (state)
      slr_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_addr;
        meta_wdata = '0;
        if (clr_addr == SLOT_W'(KEY_SLOTS - 1)) begin
          state_next = slr_pkg::ST_IDLE;
        end
      end
      slr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = slr_pkg::ST_META;
        end
      end
      slr_pkg::ST_META: begin
        state_next = slr_pkg::ST_LOAD;
      end
      slr_pkg::ST_LOAD: begin
        if (!expired) begin
          state_next = slr_pkg::ST_DECIDE;
        end
      end
      slr_pkg::ST_DECIDE: begin
        if (deny) begin
          state_next = slr_pkg::ST_RETRY;
        end else begin
          meta_we      = 1'b1;
          meta_wdata   = {head_q, cnt_q + CNT_W'(1)};
          stamp_we     = 1'b1;
          done_next    = 1'b1;
          allowed_next = 1'b1;
          state_next   = slr_pkg::ST_IDLE;
        end
      end
      slr_pkg::ST_RETRY: begin
        meta_we    = 1'b1;
        done_next  = 1'b1;
        retry_next = retry_calc;
        state_next = slr_pkg::ST_IDLE;
      end
      default: begin
        state_next = slr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      if (state == slr_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    allowed     <= allowed_next;
    retry_after <= retry_next;
    case (state)
      slr_pkg::ST_IDLE: begin
        if (start) begin
          slot_q <= slot_in;
          now_q  <= now_time;
          lim_q  <= lim_in;
          win_q  <= WIN_W'(window_seconds) << FRAC_BITS;
        end
      end
      slr_pkg::ST_META: begin
        head_q <= meta_rdata[META_W-1:CNT_W];
        cnt_q  <= meta_rdata[CNT_W-1:0];
      end
      slr_pkg::ST_LOAD: begin
        if (expired) begin
          head_q <= head_inc;
          cnt_q  <= cnt_q - CNT_W'(1);
        end else begin
          sum_q <= stamp_sum;
        end
      end
      slr_pkg::ST_DECIDE: begin
        diff_q <= sum_q - SUM_W'(now_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[slot_in];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[{slot_q, tail}] <= now_q;
    end
    stamp_rdata <= stamp_mem[{slot_q, rd_ptr}];
  end

  assign busy = (state != slr_pkg::ST_IDLE);

`include "sliding_log_rate_limiter_assert.svh"

  `SLR_ASSERT_NEXT(a_accept_starts_read, start && !busy, state == slr_pkg::ST_META)
  `SLR_ASSERT_IMP(a_done_after_decision, done,
    $past(state) == slr_pkg::ST_DECIDE || $past(state) == slr_pkg::ST_RETRY)
  `SLR_ASSERT_NEXT(a_empty_log_stops, state == slr_pkg::ST_LOAD && cnt_q == '0,
    state == slr_pkg::ST_DECIDE)
  `SLR_ASSERT_IMP(a_deny_has_delay, done && !allowed, retry_after != '0)
  `SLR_ASSERT_IMP(a_single_writer, stamp_we, meta_we && state == slr_pkg::ST_DECIDE)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sliding_log_rate_limiter, built on slr_pkg.
// A queue-fed driver issues request beats, and a monitor predicts and checks every result beat.
module tb_top;

  localparam int KEY_SLOTS = 256;
  localparam int MAX_HITS  = 16;
  localparam int FRAC_BITS = 10;

  typedef struct {
    logic [slr_pkg::KEY_W-1:0]     key;
    logic [slr_pkg::TIME_W-1:0]    now;
    logic [slr_pkg::LIMIT_W-1:0]   limit;
    logic [slr_pkg::WIN_SEC_W-1:0] win_sec;
    bit                            drain;
  } request_t;

  typedef struct {
    logic                        ok;
    logic [slr_pkg::RETRY_W-1:0] wait_secs;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [slr_pkg::KEY_W-1:0] key_slot = '0;
  logic [slr_pkg::TIME_W-1:0] now_time = '0;
  logic [slr_pkg::LIMIT_W-1:0] hit_limit = '0;
  logic [slr_pkg::WIN_SEC_W-1:0] window_seconds = '0;
  logic busy, done, allowed;
  logic [slr_pkg::RETRY_W-1:0] retry_after;

  request_t pending_q[$];
  verdict_t verdict_q[$];
  verdict_t oldest_verdict;
  bit beat_taken = 1'b0;
  int err_count = 0;
  int gap_left = 0;
  int sent_count = 0;

  logic [slr_pkg::TIME_W-1:0] hit_log [KEY_SLOTS][MAX_HITS];
  int unsigned log_head [KEY_SLOTS] = '{default: 0};
  int unsigned log_fill [KEY_SLOTS] = '{default: 0};

  sliding_log_rate_limiter #(
    .KEY_SLOTS(KEY_SLOTS),
    .MAX_HITS (MAX_HITS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .key_slot      (key_slot),
    .now_time      (now_time),
    .hit_limit     (hit_limit),
    .window_seconds(window_seconds),
    .done          (done),
    .allowed       (allowed),
    .retry_after   (retry_after)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic verdict_t judge_request(request_t r);
    int unsigned slot, head, fill, lim;
    logic [63:0] win_ticks, diff, secs;
    verdict_t v;
    slot = r.key % KEY_SLOTS;
    lim = (r.limit == 0) ? 1 : r.limit;
    if (lim > MAX_HITS) lim = MAX_HITS;
    win_ticks = 64'(r.win_sec) << FRAC_BITS;
    head = log_head[slot];
    fill = log_fill[slot];
    while (fill > 0 && 64'(hit_log[slot][head]) + win_ticks <= 64'(r.now)) begin
      head = (head + 1) % MAX_HITS;
      fill--;
    end
    if (fill >= lim) begin
      diff = 64'(hit_log[slot][head]) + win_ticks - 64'(r.now);
      secs = (diff >> FRAC_BITS) + 1;
      if (secs > slr_pkg::RETRY_MAX) secs = slr_pkg::RETRY_MAX;
      v.ok = 1'b0;
      v.wait_secs = secs[slr_pkg::RETRY_W-1:0];
    end else begin
      hit_log[slot][(head + fill) % MAX_HITS] = r.now;
      fill++;
      v.ok = 1'b1;
      v.wait_secs = '0;
    end
    log_head[slot] = head;
    log_fill[slot] = fill;
    return v;
  endfunction

  task automatic queue_request(logic [slr_pkg::KEY_W-1:0] key,
                               logic [slr_pkg::TIME_W-1:0] t, int lim, int win, bit drain);
    request_t r;
    r.key = key;
    r.now = t;
    r.limit = slr_pkg::LIMIT_W'(lim);
    r.win_sec = slr_pkg::WIN_SEC_W'(win);
    r.drain = drain;
    pending_q = {pending_q, r};
  endtask

  // A request beat is held until taken; a draining beat waits for every result first.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0 && (!pending_q[0].drain || verdict_q.size() == 0)) begin
        key_slot <= pending_q[0].key;
        now_time <= pending_q[0].now;
        hit_limit <= pending_q[0].limit;
        window_seconds <= pending_q[0].win_sec;
        start <= 1'b1;
        pending_q.pop_front();
        sent_count <= sent_count + 1;
        if (pending_q.size() > 300 && (sent_count / 120) % 2 == 0 &&
            $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(1, 18);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    beat_taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result: allowed=%0d retry_after=%0d",
                   $time, allowed, retry_after);
          err_count++;
        end else begin
          oldest_verdict = verdict_q.pop_front();
          if (allowed !== oldest_verdict.ok) begin
            $display("%0t: allowed mismatch: expected %0d, actual %0d",
                     $time, oldest_verdict.ok, allowed);
            err_count++;
          end
          if (retry_after !== oldest_verdict.wait_secs) begin
            $display("%0t: retry_after mismatch: expected %0d, actual %0d",
                     $time, oldest_verdict.wait_secs, retry_after);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        verdict_q = {verdict_q, judge_request(
          request_t'{key_slot, now_time, hit_limit, window_seconds, 1'b0})};
      end
    end
  end

  initial begin
    logic [slr_pkg::TIME_W-1:0] clock_now;
    int pick, win, lim;

    queue_request(0, 0, 1, 1, 0);
    queue_request(0, 0, 1, 1, 0);
    queue_request(0, 1023, 1, 1, 0);
    queue_request(0, 1024, 1, 1, 0);
    queue_request(255, '1, 16, 3600, 0);
    queue_request(255, 0, 1, 3600, 0);
    queue_request(255, '1, 2, 1, 0);
    // Fill one log to full depth, overflow it, then expire every stamp at once.
    for (int n = 0; n < 17; n++) queue_request(1, 5000, 16, 3600, 0);
    queue_request(1, '1, 16, 1, 0);

    clock_now = 40'd1000000;
    for (int n = 0; n < 1675; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 3) != 0) clock_now += $urandom_range(0, 1200);
        if ($urandom_range(0, 49) == 0) clock_now += $urandom_range(4096, 40000);
        win = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3600) : $urandom_range(1, 4);
        lim = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
        queue_request(slr_pkg::KEY_W'($urandom_range(0, 5) * 37), clock_now, lim, win,
                      n == 0 || $urandom_range(0, 199) == 0);
      end else if (pick < 90) begin
        queue_request(slr_pkg::KEY_W'($urandom), clock_now - $urandom_range(0, 5000),
                      $urandom_range(1, 16), $urandom_range(1, 3600), 0);
      end else begin
        queue_request(slr_pkg::KEY_W'($urandom_range(192, 255)),
                      {8'($urandom), 32'($urandom)},
                      $urandom_range(1, 16), $urandom_range(1, 3600), 0);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_q.size() > 0 || start || verdict_q.size() > 0) @(posedge clk);
    repeat (MAX_HITS + 10) @(posedge clk);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/slr_pkg.sv
design/sliding_log_rate_limiter.sv
tb/sv/tb_top.sv
